### rtl/core/fsfp_pkg.sv
`timescale 1ns / 1ps

package fsfp_pkg;

  localparam int TIME_WIDTH    = 40;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int ACC_W         = 24;
  localparam int STEP_W        = 16;
  localparam int MAXS_W        = 4;
  localparam int DROP_W        = 32;
  localparam int CNT_W         = 5;

  localparam logic [FRAC_W-1:0] ONE_FRAC = FRAC_W'(1) << FRACTION_BITS;

  // request codes
  localparam logic [1:0] REQ_RESTART = 2'd0;
  localparam logic [1:0] REQ_FRAME   = 2'd1;
  localparam logic [1:0] REQ_CONSUME = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_TIME       = 2'd0;
  localparam logic [1:0] CFG_MAX_STEPS       = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME_DELTA = 2'd2;

  localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'd4267;
  localparam logic [MAXS_W-1:0] MAX_STEPS_RST = 4'd5;
  localparam logic [STEP_W-1:0] MAX_DELTA_RST = 16'd64000;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [TIME_WIDTH-1:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [MAXS_W-1:0] pending_steps;
    logic [FRAC_W-1:0] interpolation;
    logic [DROP_W-1:0] dropped_steps;
    logic [STEP_W-1:0] frame_delta;
  } out_word_t;

  typedef struct packed {
    logic load;        // latch the word and apply restart / frame entry / consume
    logic start_whole; // start accumulator / step
    logic start_frac;  // start fraction divide
    logic div_step;    // one divider iteration
    logic cap;         // apply step cap and dropped count
    logic frac_quick;  // fraction without dividing
    logic frac_take;   // fraction from divider quotient
    logic publish;     // move result into output register
  } cmd_t;

  typedef struct packed {
    logic div_last;    // current iteration is the final one
    logic frac_quick;  // step is zero or accumulator reaches a full step
    logic steps_zero;  // nothing pending
    logic out_busy;    // output register still holds an untaken word
  } status_t;

endpackage

### rtl/core/fsfp_ctrl.sv
`timescale 1ns / 1ps

module fsfp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         req_type_i,
  input  fsfp_pkg::status_t  status_i,
  output logic               in_stall_o,
  output fsfp_pkg::cmd_t     cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SETUP  = 8'b0000_0010,
    S_DIVW   = 8'b0000_0100,
    S_CAP    = 8'b0000_1000,
    S_FRAC   = 8'b0001_0000,
    S_DIVF   = 8'b0010_0000,
    S_TAKE   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (req_type_i == fsfp_pkg::REQ_FRAME) begin
            state_d = S_SETUP;
          end else if (req_type_i == fsfp_pkg::REQ_CONSUME && !status_i.steps_zero) begin
            state_d = S_FRAC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SETUP: begin
        cmd_o.start_whole = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_CAP;
        end
      end
      S_CAP: begin
        cmd_o.cap = 1'b1;
        state_d = S_FRAC;
      end
      S_FRAC: begin
        if (status_i.frac_quick) begin
          cmd_o.frac_quick = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.start_frac = 1'b1;
          state_d = S_DIVF;
        end
      end
      S_DIVF: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.frac_take = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_divw_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVW) && status_i.div_last |=> state_q == S_CAP)
    else $error("whole divide did not hand over to cap");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> !status_i.out_busy)
    else $error("publish over an untaken word");

  a_frame_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == fsfp_pkg::REQ_FRAME) |=> state_q == S_SETUP)
    else $error("frame word did not start the divide");

endmodule

### rtl/core/fsfp_dp.sv
`timescale 1ns / 1ps

module fsfp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsfp_pkg::in_word_t            in_word_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [fsfp_pkg::STEP_W-1:0]   cfg_data_i,
  input  fsfp_pkg::cmd_t                cmd_i,
  input  logic                          out_stall_i,
  output fsfp_pkg::status_t             status_o,
  output logic                          out_valid_o,
  output fsfp_pkg::out_word_t           out_word_o
);

  localparam int TW = fsfp_pkg::TIME_WIDTH;
  localparam int AW = fsfp_pkg::ACC_W;
  localparam int SW = fsfp_pkg::STEP_W;
  localparam int MW = fsfp_pkg::MAXS_W;
  localparam int DW = fsfp_pkg::DROP_W;
  localparam int FW = fsfp_pkg::FRAC_W;
  localparam int CW = fsfp_pkg::CNT_W;

  // configuration
  logic [SW-1:0] step_q, max_delta_q;
  logic [MW-1:0] max_steps_q;

  // pacer state
  logic [TW-1:0] prev_q;
  logic [AW-1:0] acc_q, acc_d;
  logic [MW-1:0] steps_q, steps_d;
  logic [DW-1:0] drop_q, drop_d;
  logic [FW-1:0] frac_q, frac_d;
  logic [SW-1:0] delta_q, delta_d;

  // shared restoring divider
  logic [SW-1:0] rem_q, rem_d;
  logic [AW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic                 out_valid_q;
  fsfp_pkg::out_word_t  out_q;

  // frame entry terms
  logic [TW-1:0] elapsed;
  logic [SW-1:0] delta_clamped;
  logic [AW:0]   acc_sum;
  // divider terms
  logic [SW:0]   trial;
  logic          trial_ge;
  // cap terms
  logic [AW-1:0] whole;
  logic [AW-1:0] excess;
  logic [DW:0]   drop_sum;
  logic [SW+MW-1:0] capped_acc;
  logic          acc_ge_step;

  assign elapsed       = in_word_i.now_time - prev_q;
  assign delta_clamped = (in_word_i.now_time <= prev_q) ? '0 :
                         (elapsed > TW'(max_delta_q)) ? max_delta_q : elapsed[SW-1:0];
  assign acc_sum       = {1'b0, acc_q} + (AW+1)'(delta_clamped);

  assign trial    = {rem_q, quo_q[AW-1]};
  assign trial_ge = trial >= {1'b0, step_q};

  assign whole       = (step_q == '0) ? '0 : quo_q;
  assign excess      = whole - AW'(max_steps_q);
  assign drop_sum    = {1'b0, drop_q} + (DW+1)'(excess);
  assign capped_acc  = (SW+MW)'(step_q) * (SW+MW)'(max_steps_q);
  assign acc_ge_step = acc_q >= AW'(step_q);

  always_comb begin
    acc_d   = acc_q;
    steps_d = steps_q;
    drop_d  = drop_q;
    frac_d  = frac_q;
    delta_d = delta_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;

    if (cmd_i.load) begin
      case (in_word_i.req_type)
        fsfp_pkg::REQ_RESTART: begin
          acc_d   = '0;
          steps_d = '0;
          drop_d  = '0;
          frac_d  = '0;
          delta_d = '0;
        end
        fsfp_pkg::REQ_FRAME: begin
          delta_d = delta_clamped;
          acc_d   = acc_sum[AW] ? '1 : acc_sum[AW-1:0];
        end
        fsfp_pkg::REQ_CONSUME: begin
          if (steps_q != '0) begin
            acc_d   = acc_ge_step ? acc_q - AW'(step_q) : '0;
            steps_d = steps_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.start_whole) begin
      rem_d = '0;
      quo_d = acc_q;
      cnt_d = CW'(AW - 1);
    end
    if (cmd_i.start_frac) begin
      // accumulator is below step here, so it fits the remainder
      rem_d = acc_q[SW-1:0];
      quo_d = '0;
      cnt_d = CW'(fsfp_pkg::FRACTION_BITS - 1);
    end
    if (cmd_i.div_step) begin
      rem_d = trial_ge ? SW'(trial - {1'b0, step_q}) : trial[SW-1:0];
      quo_d = {quo_q[AW-2:0], trial_ge};
      cnt_d = cnt_q - 1'b1;
    end

    if (cmd_i.cap) begin
      if (whole > AW'(max_steps_q)) begin
        drop_d  = drop_sum[DW] ? '1 : drop_sum[DW-1:0];
        acc_d   = AW'(capped_acc);
        steps_d = max_steps_q;
      end else begin
        steps_d = whole[MW-1:0];
      end
    end
    if (cmd_i.frac_quick) begin
      frac_d = (step_q == '0) ? '0 : fsfp_pkg::ONE_FRAC;
    end
    if (cmd_i.frac_take) begin
      frac_d = {1'b0, quo_q[FW-2:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= fsfp_pkg::STEP_TIME_RST;
      max_steps_q <= fsfp_pkg::MAX_STEPS_RST;
      max_delta_q <= fsfp_pkg::MAX_DELTA_RST;
      prev_q      <= '0;
      acc_q       <= '0;
      steps_q     <= '0;
      drop_q      <= '0;
      frac_q      <= '0;
      delta_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fsfp_pkg::CFG_STEP_TIME:       step_q      <= cfg_data_i;
          fsfp_pkg::CFG_MAX_STEPS:       max_steps_q <= cfg_data_i[MW-1:0];
          fsfp_pkg::CFG_MAX_FRAME_DELTA: max_delta_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.load && in_word_i.req_type != fsfp_pkg::REQ_CONSUME) begin
        if (in_word_i.req_type == fsfp_pkg::REQ_RESTART
            || in_word_i.req_type == fsfp_pkg::REQ_FRAME) begin
          prev_q <= in_word_i.now_time;
        end
      end
      acc_q   <= acc_d;
      steps_q <= steps_d;
      drop_q  <= drop_d;
      frac_q  <= frac_d;
      delta_q <= delta_d;
      cnt_q   <= cnt_d;
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.publish) begin
      out_q.pending_steps <= steps_q;
      out_q.interpolation <= frac_q;
      out_q.dropped_steps <= drop_q;
      out_q.frame_delta   <= delta_q;
    end
  end

  assign status_o.div_last   = (cnt_q == '0);
  assign status_o.frac_quick = (step_q == '0) || acc_ge_step;
  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= fsfp_pkg::ONE_FRAC)
    else $error("interpolation above one");

  a_take_below_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_frac |-> (step_q != '0) && (acc_q < AW'(step_q)))
    else $error("fraction divide started with a full step");

  a_consume_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && (in_word_i.req_type == fsfp_pkg::REQ_CONSUME) && (steps_q != '0)
    |=> steps_q == $past(steps_q) - 1'b1)
    else $error("consume did not retire one step");

endmodule

### rtl/core/fixed_step_frame_pacer_unit.sv
`timescale 1ns / 1ps
// Restart, unused and idle-consume words go straight to output. A consume with steps
// pending runs the fraction step; a frame runs the whole-step divide and cap before it.
// The fraction divide is skipped when step is zero or a full step remains. The shared
// one-bit-per-cycle divider makes 24 bits for whole steps, 16 for the fraction.
// One word at a time: the next is taken in the cycle after the result loads,
// which waits while an earlier result is stalled. Async active-low reset clears state.
module fixed_step_frame_pacer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fsfp_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fsfp_pkg::out_word_t          out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [fsfp_pkg::STEP_W-1:0]  cfg_data_i
);

  fsfp_pkg::cmd_t    cmd;
  fsfp_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  fsfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_word_i.req_type),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  fsfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.interpolation <= fsfp_pkg::ONE_FRAC)
    else $error("interpolation word out of range");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no word in flight");

endmodule
